// ===== design/char_lcd_nibble_command_engine_core_assert.svh =====
// Assertion macros for the checker module.
`ifndef CHAR_LCD_NIBBLE_COMMAND_ENGINE_CORE_ASSERT_SVH
`define CHAR_LCD_NIBBLE_COMMAND_ENGINE_CORE_ASSERT_SVH

// Same-cycle implication, sampled on clk_i, off during reset.
`define LCDNCE_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk_i, off during reset.
`define LCDNCE_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== design/lcdnce_pkg.sv =====
package lcdnce_pkg;

  localparam int MaxDigits = 5;
  localparam int IdxW      = (MaxDigits > 1) ? $clog2(MaxDigits) : 1;
  localparam int WsatW     = $clog2(MaxDigits + 1);
  localparam int PcW       = 5;

  // Command codes
  localparam logic [2:0] FUNC_INIT     = 3'd0;
  localparam logic [2:0] FUNC_CLEAR    = 3'd1;
  localparam logic [2:0] FUNC_GOTO     = 3'd2;
  localparam logic [2:0] FUNC_CHAR     = 3'd3;
  localparam logic [2:0] FUNC_NUMBER   = 3'd4;
  localparam logic [2:0] FUNC_CURS_ON  = 3'd5;
  localparam logic [2:0] FUNC_CURS_OFF = 3'd6;

  // Pause classes after an enable pulse
  localparam logic [1:0] WAIT_NIB   = 2'd0;
  localparam logic [1:0] WAIT_BYTE  = 2'd1;
  localparam logic [1:0] WAIT_INIT  = 2'd2;
  localparam logic [1:0] WAIT_CLEAR = 2'd3;

  localparam logic [7:0] CMD_SET_DDRAM   = 8'h80;
  localparam logic [7:0] LINE1_BASE      = 8'h40;
  localparam logic [7:0] CMD_CURS_BLOCK  = 8'h0F;
  localparam logic [7:0] CMD_CURS_LINE   = 8'h0E;
  localparam logic [7:0] CMD_CURS_HIDDEN = 8'h0C;
  localparam logic [3:0] ASCII_DIGIT_HI  = 4'h3;

  // Program entry points
  localparam logic [PcW-1:0] PC_INIT   = 5'd0;
  localparam logic [PcW-1:0] PC_CLEAR  = 5'd14;
  localparam logic [PcW-1:0] PC_BYTE   = 5'd18;
  localparam logic [PcW-1:0] PC_DIV    = 5'd20;
  localparam logic [PcW-1:0] PC_OUT_HI = 5'd21;

  typedef struct packed {
    logic [2:0]  func;
    logic [7:0]  ch;
    logic [5:0]  x;
    logic        y;
    logic        keep_position;
    logic [15:0] value;
    logic [3:0]  width;
    logic [7:0]  pad;
    logic        block_cursor;
  } in_t;

  typedef struct packed {
    logic       rs;
    logic [3:0] nibble;
    logic [1:0] wait_code;
    logic [5:0] cur_x;
    logic       cur_y;
    logic       last;
  } out_t;

  typedef enum logic [2:0] {
    NSRC_NONE,
    NSRC_CONST,
    NSRC_OP_HI,
    NSRC_OP_LO,
    NSRC_TXT_HI,
    NSRC_TXT_LO
  } nsrc_e;

  typedef enum logic [1:0] {
    SEQ_NEXT,
    SEQ_END,
    SEQ_DIV,
    SEQ_OUT
  } seq_e;

  typedef struct packed {
    nsrc_e          nsrc;
    logic [3:0]     nib;
    logic [1:0]     wcode;
    seq_e           seq;
    logic [PcW-1:0] target;
  } ctl_t;

  function automatic ctl_t cw(input nsrc_e s, input logic [3:0] n, input logic [1:0] w,
                              input seq_e q, input logic [PcW-1:0] t);
    ctl_t c;
    c.nsrc   = s;
    c.nib    = n;
    c.wcode  = w;
    c.seq    = q;
    c.target = t;
    return c;
  endfunction

  // Control store
  function automatic ctl_t ucode(input logic [PcW-1:0] pc);
    ctl_t c;
    unique case (pc)
      5'd0, 5'd1, 5'd2: c = cw(NSRC_CONST, 4'h3, WAIT_INIT, SEQ_NEXT, PC_INIT);
      5'd3:  c = cw(NSRC_CONST, 4'h2, WAIT_INIT,  SEQ_NEXT, PC_INIT);
      5'd4:  c = cw(NSRC_CONST, 4'h2, WAIT_NIB,   SEQ_NEXT, PC_INIT);
      5'd5:  c = cw(NSRC_CONST, 4'h8, WAIT_INIT,  SEQ_NEXT, PC_INIT);
      5'd6:  c = cw(NSRC_CONST, 4'h0, WAIT_NIB,   SEQ_NEXT, PC_INIT);
      5'd7:  c = cw(NSRC_CONST, 4'h8, WAIT_INIT,  SEQ_NEXT, PC_INIT);
      5'd8:  c = cw(NSRC_CONST, 4'h0, WAIT_NIB,   SEQ_NEXT, PC_INIT);
      5'd9:  c = cw(NSRC_CONST, 4'h1, WAIT_INIT,  SEQ_NEXT, PC_INIT);
      5'd10: c = cw(NSRC_CONST, 4'h0, WAIT_NIB,   SEQ_NEXT, PC_INIT);
      5'd11: c = cw(NSRC_CONST, 4'hE, WAIT_INIT,  SEQ_NEXT, PC_INIT);
      5'd12: c = cw(NSRC_CONST, 4'h0, WAIT_NIB,   SEQ_NEXT, PC_INIT);
      5'd13: c = cw(NSRC_CONST, 4'h6, WAIT_INIT,  SEQ_NEXT, PC_INIT);
      5'd14: c = cw(NSRC_CONST, 4'h0, WAIT_NIB,   SEQ_NEXT, PC_INIT);
      5'd15: c = cw(NSRC_CONST, 4'h1, WAIT_CLEAR, SEQ_NEXT, PC_INIT);
      5'd16: c = cw(NSRC_CONST, 4'h8, WAIT_NIB,   SEQ_NEXT, PC_INIT);
      5'd17: c = cw(NSRC_CONST, 4'h0, WAIT_BYTE,  SEQ_END,  PC_INIT);
      5'd18: c = cw(NSRC_OP_HI, 4'h0, WAIT_NIB,   SEQ_NEXT, PC_INIT);
      5'd19: c = cw(NSRC_OP_LO, 4'h0, WAIT_BYTE,  SEQ_END,  PC_INIT);
      5'd20: c = cw(NSRC_NONE,  4'h0, WAIT_NIB,   SEQ_DIV,  PC_DIV);
      5'd21: c = cw(NSRC_TXT_HI, 4'h0, WAIT_NIB,  SEQ_NEXT, PC_INIT);
      5'd22: c = cw(NSRC_TXT_LO, 4'h0, WAIT_BYTE, SEQ_OUT,  PC_OUT_HI);
      default: c = cw(NSRC_NONE, 4'h0, WAIT_NIB,  SEQ_END,  PC_INIT);
    endcase
    return c;
  endfunction

endpackage

// ===== design/lcdnce_div10.sv =====
// Divide by ten through a reciprocal multiply; exact for all 16-bit values.
module lcdnce_div10 (
  input  logic [15:0] value_i,
  output logic [15:0] quot_o,
  output logic [3:0]  rem_o
);
  logic [32:0] prod;
  logic [15:0] back;

  assign prod   = {17'd0, value_i} * 33'd52429;
  assign quot_o = {2'b00, prod[32:19]};
  assign back   = {quot_o[12:0], 3'b000} + {quot_o[14:0], 1'b0};
  assign rem_o  = 4'(value_i - back);
endmodule

// ===== design/char_lcd_nibble_command_engine_core.sv =====
// Command engine for a 4-bit character LCD.
// The request channel (in_valid_i / in_ready_o / in_data_i) takes one command:
// init, clear, goto, write char, write number, cursor on or cursor off.
// Each command becomes a run of nibble transfers on the result channel
// (out_valid_o / out_ready_i / out_data_o), high nibble of each byte first,
// with register select, wait class, tracked cursor and a last mark.
// A microcoded sequencer steps through a small control store, one step per
// cycle; a transfer step moves only when the output register is free or is
// being taken, so transfer steps give one nibble per cycle when never stalled.
// Transfers per command: init 18, clear 4, number 2*w, others 2. Write number
// first runs w steps of the divide-by-ten loop (w = width capped at 5). The
// request loads the sequencer state, and the first transfer then enters the
// output register, after the divide loop for write number.
// in_ready_o is low while a command is in progress and rises once its last
// transfer sits in the output register; a stalled receiver holds the step.
// Func 7 and write number with width 0 produce nothing.
// Reset clears the tracked cursor to column 0, line 0 and empties the output.
module char_lcd_nibble_command_engine_core (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  lcdnce_pkg::in_t    in_data_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output lcdnce_pkg::out_t   out_data_o
);
  import lcdnce_pkg::*;

  logic                 busy_q, busy_d;
  logic [PcW-1:0]       pc_q, pc_d;
  logic [IdxW-1:0]      idx_q, idx_d;
  logic [WsatW-1:0]     wsat_q, wsat_d;
  logic [7:0]           op_q, op_d;
  logic                 rs_q, rs_d;
  logic [15:0]          val_q, val_d;
  logic [7:0]           pad_q, pad_d;
  logic [5:0]           column_q, column_d;
  logic                 line_q, line_d;
  logic [7:0]           text_q [MaxDigits];
  logic                 out_valid_q, out_valid_d;
  out_t                 out_q;

  ctl_t                 ctl;
  logic                 accept, emit, advance, at_last_idx, load;
  logic [WsatW-1:0]     width_sat;
  logic [IdxW-1:0]      last_idx;
  logic [WsatW-1:0]     last_w;
  logic [15:0]          quot;
  logic [3:0]           rem;
  logic [7:0]           digit;
  logic [7:0]           txt;
  logic [3:0]           nib;
  logic [6:0]           addr_sum;
  logic                 text_we;

  lcdnce_div10 u_div10 (
    .value_i (val_q),
    .quot_o  (quot),
    .rem_o   (rem)
  );

  assign in_ready_o  = !busy_q;
  assign accept      = in_valid_i && !busy_q;
  assign width_sat   = (in_data_i.width > 4'(MaxDigits)) ? WsatW'(MaxDigits)
                                                         : WsatW'(in_data_i.width);
  assign addr_sum    = {1'b0, in_data_i.x} + (in_data_i.y ? LINE1_BASE[6:0] : 7'd0);

  assign ctl         = ucode(pc_q);
  assign emit        = (ctl.nsrc != NSRC_NONE);
  assign advance     = busy_q && (!emit || !out_valid_q || out_ready_i);
  assign load        = advance && emit;
  assign last_w      = wsat_q - 1'b1;
  assign last_idx    = IdxW'(last_w);
  assign at_last_idx = (idx_q == last_idx);
  assign txt         = text_q[idx_q];

  // Leading positions show the pad once the value has run out of digits.
  assign digit   = (at_last_idx || val_q != 16'd0) ? {ASCII_DIGIT_HI, rem} : pad_q;
  assign text_we = advance && (ctl.seq == SEQ_DIV);

  always_comb begin
    case (ctl.nsrc)
      NSRC_CONST:  nib = ctl.nib;
      NSRC_OP_HI:  nib = op_q[7:4];
      NSRC_OP_LO:  nib = op_q[3:0];
      NSRC_TXT_HI: nib = txt[7:4];
      NSRC_TXT_LO: nib = txt[3:0];
      default:     nib = 4'h0;
    endcase
  end

  always_comb begin
    busy_d   = busy_q;
    pc_d     = pc_q;
    idx_d    = idx_q;
    wsat_d   = wsat_q;
    op_d     = op_q;
    rs_d     = rs_q;
    val_d    = val_q;
    pad_d    = pad_q;
    column_d = column_q;
    line_d   = line_q;

    if (accept) begin
      unique case (in_data_i.func)
        FUNC_INIT, FUNC_CLEAR: begin
          busy_d   = 1'b1;
          pc_d     = (in_data_i.func == FUNC_INIT) ? PC_INIT : PC_CLEAR;
          rs_d     = 1'b0;
          column_d = 6'd0;
          line_d   = 1'b0;
        end
        FUNC_GOTO: begin
          busy_d = 1'b1;
          pc_d   = PC_BYTE;
          rs_d   = 1'b0;
          op_d   = CMD_SET_DDRAM | {1'b0, addr_sum};
          if (!in_data_i.keep_position) begin
            column_d = in_data_i.x;
            line_d   = in_data_i.y;
          end
        end
        FUNC_CHAR: begin
          busy_d = 1'b1;
          pc_d   = PC_BYTE;
          rs_d   = 1'b1;
          op_d   = in_data_i.ch;
        end
        FUNC_NUMBER: begin
          if (width_sat != '0) begin
            busy_d = 1'b1;
            pc_d   = PC_DIV;
            rs_d   = 1'b1;
            wsat_d = width_sat;
            idx_d  = IdxW'(width_sat - 1'b1);
            val_d  = in_data_i.value;
            pad_d  = in_data_i.pad;
          end
        end
        FUNC_CURS_ON: begin
          busy_d = 1'b1;
          pc_d   = PC_BYTE;
          rs_d   = 1'b0;
          op_d   = in_data_i.block_cursor ? CMD_CURS_BLOCK : CMD_CURS_LINE;
        end
        FUNC_CURS_OFF: begin
          busy_d = 1'b1;
          pc_d   = PC_BYTE;
          rs_d   = 1'b0;
          op_d   = CMD_CURS_HIDDEN;
        end
        default: begin
        end
      endcase
    end else if (advance) begin
      unique case (ctl.seq)
        SEQ_NEXT: pc_d = pc_q + 1'b1;
        SEQ_END:  busy_d = 1'b0;
        SEQ_DIV: begin
          // Digits fill right to left; leave idx at zero for the send loop.
          val_d = quot;
          if (idx_q == '0) begin
            pc_d = pc_q + 1'b1;
          end else begin
            idx_d = idx_q - 1'b1;
            pc_d  = ctl.target;
          end
        end
        SEQ_OUT: begin
          if (at_last_idx) begin
            busy_d = 1'b0;
          end else begin
            idx_d = idx_q + 1'b1;
            pc_d  = ctl.target;
          end
        end
        default: busy_d = 1'b0;
      endcase
    end
  end

  assign out_valid_d = load || (out_valid_q && !out_ready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      pc_q        <= PC_INIT;
      idx_q       <= '0;
      wsat_q      <= '0;
      column_q    <= 6'd0;
      line_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      busy_q      <= busy_d;
      pc_q        <= pc_d;
      idx_q       <= idx_d;
      wsat_q      <= wsat_d;
      column_q    <= column_d;
      line_q      <= line_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q  <= op_d;
    rs_q  <= rs_d;
    val_q <= val_d;
    pad_q <= pad_d;
    if (text_we) begin
      text_q[idx_q] <= digit;
    end
    if (load) begin
      out_q.rs        <= rs_q;
      out_q.nibble    <= nib;
      out_q.wait_code <= ctl.wcode;
      out_q.cur_x     <= column_q;
      out_q.cur_y     <= line_q;
      out_q.last      <= (ctl.seq == SEQ_END) || (ctl.seq == SEQ_OUT && at_last_idx);
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;
endmodule

// ===== design/lcdnce_checker.sv =====
`include "char_lcd_nibble_command_engine_core_assert.svh"

module lcdnce_checker (
  input logic             clk_i,
  input logic             rst_ni,
  input logic             in_ready_o,
  input logic             out_valid_o,
  input logic             out_ready_i,
  input lcdnce_pkg::out_t out_data_o
);
  import lcdnce_pkg::*;

  // A stalled transfer stays offered.
  `LCDNCE_ASSERT_NEXT(a_out_hold, out_valid_o && !out_ready_i, out_valid_o, "transfer dropped")

  // A command that still owes transfers cannot take a new request.
  `LCDNCE_ASSERT_NOW(a_busy_mid_cmd, out_valid_o && !out_data_o.last, !in_ready_o, "request taken mid-command")

  // Data bytes only ever pause for a nibble or byte gap.
  `LCDNCE_ASSERT_NOW(a_data_wait, out_valid_o && out_data_o.rs, out_data_o.wait_code == WAIT_NIB || out_data_o.wait_code == WAIT_BYTE, "bad wait on data")

  // The long pause follows only the low nibble of the clear instruction.
  `LCDNCE_ASSERT_NOW(a_clear_wait, out_valid_o && out_data_o.wait_code == WAIT_CLEAR, out_data_o.nibble == 4'h1 && !out_data_o.rs && !out_data_o.last, "bad clear pause")
endmodule

bind char_lcd_nibble_command_engine_core lcdnce_checker u_lcdnce_checker (.*);

// ===== sim/lcd_xfer_board_pkg.sv =====
package lcd_xfer_board_pkg;
  import lcdnce_pkg::*;

  localparam logic [2:0] FUNC_UNDEF = 3'd7;

  localparam logic RS_INSTR = 1'b0;
  localparam logic RS_DATA  = 1'b1;

  localparam logic [7:0] LCD_FUNCTION_SET = 8'h28;
  localparam logic [7:0] LCD_DISPLAY_OFF  = 8'h08;
  localparam logic [7:0] LCD_CLEAR        = 8'h01;
  localparam logic [7:0] LCD_ENTRY_MODE   = 8'h06;
  localparam logic [3:0] WAKE_NIB         = 4'h3;
  localparam logic [3:0] BUS4_NIB         = 4'h2;

  // Predicts the nibble transfers of each command and checks them in order.
  class lcd_xfer_board;
    out_t        expected_xfers[$];
    out_t        staged[$];
    logic [5:0]  track_col;
    logic        track_line;
    int unsigned errors;

    function new();
      track_col  = '0;
      track_line = 1'b0;
      errors     = 0;
    endfunction

    function void put_nibble(logic rs, logic [3:0] nib, logic [1:0] wcode);
      out_t t;
      t           = '0;
      t.rs        = rs;
      t.nibble    = nib;
      t.wait_code = wcode;
      staged.push_back(t);
    endfunction

    // High nibble first, its pause is always the short one.
    function void put_byte(logic rs, logic [7:0] b, logic [1:0] wait_low);
      put_nibble(rs, b[7:4], WAIT_NIB);
      put_nibble(rs, b[3:0], wait_low);
    endfunction

    function void put_clear();
      put_byte(RS_INSTR, LCD_CLEAR, WAIT_CLEAR);
      put_byte(RS_INSTR, CMD_SET_DDRAM, WAIT_BYTE);
      track_col  = '0;
      track_line = 1'b0;
    endfunction

    function void note_command(in_t cmd);
      int unsigned w;
      int unsigned v;
      logic [7:0]  text[MaxDigits];
      logic [7:0]  addr;
      staged.delete();
      case (cmd.func)
        FUNC_INIT: begin
          repeat (3) put_nibble(RS_INSTR, WAKE_NIB, WAIT_INIT);
          put_nibble(RS_INSTR, BUS4_NIB, WAIT_INIT);
          put_byte(RS_INSTR, LCD_FUNCTION_SET, WAIT_INIT);
          put_byte(RS_INSTR, LCD_DISPLAY_OFF, WAIT_INIT);
          put_byte(RS_INSTR, LCD_CLEAR, WAIT_INIT);
          put_byte(RS_INSTR, CMD_CURS_LINE, WAIT_INIT);
          put_byte(RS_INSTR, LCD_ENTRY_MODE, WAIT_INIT);
          put_clear();
        end
        FUNC_CLEAR: put_clear();
        FUNC_GOTO: begin
          addr = CMD_SET_DDRAM | (8'(cmd.x) + (cmd.y ? LINE1_BASE : 8'h00));
          put_byte(RS_INSTR, addr, WAIT_BYTE);
          if (!cmd.keep_position) begin
            track_col  = cmd.x;
            track_line = cmd.y;
          end
        end
        FUNC_CHAR: put_byte(RS_DATA, cmd.ch, WAIT_BYTE);
        FUNC_NUMBER: begin
          w = (cmd.width > MaxDigits) ? MaxDigits : cmd.width;
          v = cmd.value;
          // fill right to left; the rightmost place always gets a digit
          for (int i = int'(w) - 1; i >= 0; i--) begin
            if (i == int'(w) - 1 || v != 0) begin
              text[i] = {ASCII_DIGIT_HI, 4'(v % 10)};
              v       = v / 10;
            end else begin
              text[i] = cmd.pad;
            end
          end
          for (int i = 0; i < int'(w); i++) put_byte(RS_DATA, text[i], WAIT_BYTE);
        end
        FUNC_CURS_ON: begin
          put_byte(RS_INSTR, cmd.block_cursor ? CMD_CURS_BLOCK : CMD_CURS_LINE, WAIT_BYTE);
        end
        FUNC_CURS_OFF: put_byte(RS_INSTR, CMD_CURS_HIDDEN, WAIT_BYTE);
        default: ;
      endcase
      foreach (staged[k]) begin
        staged[k].cur_x = track_col;
        staged[k].cur_y = track_line;
        staged[k].last  = (k == staged.size() - 1);
        expected_xfers.push_back(staged[k]);
      end
    endfunction

    function void compare_field(string field, logic [7:0] want, logic [7:0] got);
      if (got !== want) begin
        $error("%s: expected %0h, got %0h", field, want, got);
        errors++;
      end
    endfunction

    function void check_transfer(out_t got);
      out_t want;
      if (expected_xfers.size() == 0) begin
        $error("transfer with none expected: rs %0d nibble %0h", got.rs, got.nibble);
        errors++;
        return;
      end
      want = expected_xfers.pop_front();
      compare_field("rs", 8'(want.rs), 8'(got.rs));
      compare_field("nibble", 8'(want.nibble), 8'(got.nibble));
      compare_field("wait_code", 8'(want.wait_code), 8'(got.wait_code));
      compare_field("cur_x", 8'(want.cur_x), 8'(got.cur_x));
      compare_field("cur_y", 8'(want.cur_y), 8'(got.cur_y));
      compare_field("last", 8'(want.last), 8'(got.last));
    endfunction
  endclass

endpackage

// ===== sim/tb_top.sv =====
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import lcdnce_pkg::*;
  import lcd_xfer_board_pkg::*;

  localparam int unsigned STALL_LIMIT    = 3000;
  localparam int unsigned HOLDOFF_CYCLES = 400;
  localparam int unsigned RANDOM_CMDS    = 280;
  localparam int unsigned DRAIN_CYCLES   = 40;

  logic clk_i = 1'b0;
  logic rst_ni;
  logic in_valid_i;
  logic in_ready_o;
  in_t  in_data_i;
  logic out_valid_o;
  logic out_ready_i;
  out_t out_data_o;

  lcd_xfer_board board = new();

  bit          send_quiet;
  bit          recv_quiet;
  bit          start_holdoff;
  int unsigned stall_cycles;

  always #1 clk_i = ~clk_i;

  char_lcd_nibble_command_engine_core dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_data_o (out_data_o)
  );

  function automatic in_t command(logic [2:0] func, logic [7:0] ch, logic [5:0] x, logic y,
                                  logic keep, logic [15:0] value, logic [3:0] width,
                                  logic [7:0] pad, logic blk);
    in_t c;
    c.func          = func;
    c.ch            = ch;
    c.x             = x;
    c.y             = y;
    c.keep_position = keep;
    c.value         = value;
    c.width         = width;
    c.pad           = pad;
    c.block_cursor  = blk;
    return c;
  endfunction

  function automatic in_t random_command();
    logic [63:0] r;
    in_t         c;
    int unsigned pick;
    r    = {$urandom(), $urandom()};
    c    = r[$bits(in_t)-1:0];
    pick = $urandom_range(0, 99);
    if (pick < 4) c.func = FUNC_INIT;
    else if (pick < 10) c.func = FUNC_CLEAR;
    else if (pick < 25) c.func = FUNC_GOTO;
    else if (pick < 48) c.func = FUNC_CHAR;
    else if (pick < 75) c.func = FUNC_NUMBER;
    else if (pick < 85) c.func = FUNC_CURS_ON;
    else if (pick < 95) c.func = FUNC_CURS_OFF;
    else c.func = FUNC_UNDEF;
    // short numbers bring out the padding
    if ($urandom_range(0, 3) == 0) c.value = 16'($urandom_range(0, 99));
    return c;
  endfunction

  task automatic send_cmd(input in_t cmd);
    while (!send_quiet && $urandom_range(0, 99) < 20) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= cmd;
    do @(posedge clk_i); while (!in_ready_o);
    board.note_command(cmd);
  endtask

  initial begin : receiver
    int unsigned holdoff_left;
    holdoff_left = 0;
    forever begin
      @(posedge clk_i);
      if (rst_ni && out_valid_o && out_ready_i) board.check_transfer(out_data_o);
      if (holdoff_left != 0) begin
        holdoff_left--;
        out_ready_i <= 1'b0;
      end else if (start_holdoff) begin
        // hold the output so the engine backs up into its request side
        start_holdoff = 1'b0;
        holdoff_left  = HOLDOFF_CYCLES;
        out_ready_i  <= 1'b0;
      end else begin
        out_ready_i <= recv_quiet || ($urandom_range(0, 99) >= 20);
      end
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
    if (stall_cycles >= STALL_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  initial begin
    int unsigned real_cmds;
    int unsigned n;
    in_t         c;
    rst_ni        <= 1'b0;
    in_valid_i    <= 1'b0;
    in_data_i     <= '0;
    out_ready_i   <= 1'b0;
    send_quiet    = 1'b0;
    recv_quiet    = 1'b0;
    start_holdoff = 1'b0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    send_cmd(command(FUNC_INIT, 8'h00, 6'd0, 1'b0, 1'b0, 16'd0, 4'd0, 8'h00, 1'b0));
    send_cmd(command(FUNC_CHAR, 8'h00, 6'd0, 1'b0, 1'b0, 16'd0, 4'd0, 8'h00, 1'b0));
    send_cmd(command(FUNC_CHAR, 8'hFF, 6'h3F, 1'b1, 1'b1, 16'hFFFF, 4'hF, 8'hFF, 1'b1));
    send_cmd(command(FUNC_GOTO, 8'h00, 6'd0, 1'b0, 1'b0, 16'd0, 4'd0, 8'h00, 1'b0));
    send_cmd(command(FUNC_GOTO, 8'h00, 6'd63, 1'b1, 1'b0, 16'd0, 4'd0, 8'h00, 1'b0));
    send_cmd(command(FUNC_GOTO, 8'h00, 6'd39, 1'b0, 1'b1, 16'd0, 4'd0, 8'h00, 1'b0));
    send_cmd(command(FUNC_NUMBER, 8'h00, 6'd0, 1'b0, 1'b0, 16'd0, 4'd5, 8'h20, 1'b0));
    send_cmd(command(FUNC_NUMBER, 8'h00, 6'd0, 1'b0, 1'b0, 16'hFFFF, 4'd5, 8'h20, 1'b0));
    send_cmd(command(FUNC_NUMBER, 8'h00, 6'd0, 1'b0, 1'b0, 16'd9, 4'd15, 8'hFF, 1'b0));
    send_cmd(command(FUNC_NUMBER, 8'h00, 6'd0, 1'b0, 1'b0, 16'd12345, 4'd2, 8'h20, 1'b0));
    send_cmd(command(FUNC_NUMBER, 8'h00, 6'd0, 1'b0, 1'b0, 16'd7, 4'd0, 8'h20, 1'b0));
    send_cmd(command(FUNC_NUMBER, 8'h00, 6'd0, 1'b0, 1'b0, 16'd42, 4'd4, 8'h00, 1'b0));
    send_cmd(command(FUNC_NUMBER, 8'h00, 6'd0, 1'b0, 1'b0, 16'd100, 4'd1, 8'h2A, 1'b0));
    send_cmd(command(FUNC_CURS_ON, 8'h00, 6'd0, 1'b0, 1'b0, 16'd0, 4'd0, 8'h00, 1'b1));
    send_cmd(command(FUNC_CURS_ON, 8'h00, 6'd0, 1'b0, 1'b0, 16'd0, 4'd0, 8'h00, 1'b0));
    send_cmd(command(FUNC_CURS_OFF, 8'h00, 6'd0, 1'b0, 1'b0, 16'd0, 4'd0, 8'h00, 1'b0));
    send_cmd(command(FUNC_UNDEF, 8'h41, 6'd5, 1'b1, 1'b0, 16'd5, 4'd5, 8'h20, 1'b1));
    send_cmd(command(FUNC_GOTO, 8'h00, 6'd5, 1'b1, 1'b0, 16'd0, 4'd0, 8'h00, 1'b0));
    send_cmd(command(FUNC_CLEAR, 8'h00, 6'd0, 1'b0, 1'b0, 16'd0, 4'd0, 8'h00, 1'b0));

    real_cmds = 0;
    n         = 0;
    while (real_cmds < RANDOM_CMDS) begin
      if (n == 60 || n == 230) start_holdoff = 1'b1;
      send_quiet = (n >= 120 && n < 170);
      recv_quiet = send_quiet;
      if (n == 200) begin
        // drain the engine completely before going on
        in_valid_i <= 1'b0;
        do @(posedge clk_i); while (board.expected_xfers.size() != 0);
      end
      c = random_command();
      send_cmd(c);
      if (!(c.func == FUNC_UNDEF || (c.func == FUNC_NUMBER && c.width == 0))) real_cmds++;
      n++;
    end
    in_valid_i <= 1'b0;

    while (board.expected_xfers.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (board.expected_xfers.size() != 0) begin
      $error("%0d expected transfers never arrived", board.expected_xfers.size());
      board.errors++;
    end
    if (board.errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
